>>> design/ppc_pkg.sv
`timescale 1ns / 1ps

package ppc_pkg;

   localparam logic [1:0] MODE_GRAY     = 2'd0;
   localparam logic [1:0] MODE_COLOUR   = 2'd1;
   localparam logic [1:0] MODE_UNPREMUL = 2'd2;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned GRAY_W   = 10;
   localparam int unsigned REM_W    = 16;
   localparam int unsigned CHANNELS = 3;

   localparam logic [CHAN_W-1:0] OPAQUE   = 8'd255;
   localparam logic [GRAY_W-1:0] GRAY_MAX = 10'd765;

   typedef struct packed {
      logic [1:0]                          mode;
      logic [CHAN_W-1:0]                   alpha;
      logic [GRAY_W-1:0]                   gray;
      logic [CHANNELS-1:0]                 div;
      logic [CHANNELS-1:0][CHAN_W-1:0]     quo;
      logic [CHANNELS-1:0][REM_W-1:0]      rem;
   } stage_type;

endpackage

>>> design/ppc_if.sv
`timescale 1ns / 1ps

interface ppc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;
   logic [7:0] in_alpha;

   modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface ppc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   logic [9:0] gray_level;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, gray_level,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, gray_level,
                   output ready);
endinterface

interface ppc_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> design/ppc_front_cell.sv
`timescale 1ns / 1ps

module ppc_front_cell (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         enable,
   input  logic [1:0]                                   mode,
   input  logic                                         up_valid,
   input  logic [ppc_pkg::CHANNELS-1:0][ppc_pkg::CHAN_W-1:0] chan,
   input  logic [ppc_pkg::CHAN_W-1:0]                   alpha,
   output logic                                         valid_out,
   output ppc_pkg::stage_type                           stage_out
);

   logic                           valid_ff;
   ppc_pkg::stage_type             stage_ff;
   ppc_pkg::stage_type             stage_in;
   logic [ppc_pkg::CHAN_W-1:0]     white;
   logic [10:0]                    sum;
   logic [ppc_pkg::REM_W-1:0]      limit;
   logic [ppc_pkg::CHANNELS-1:0][ppc_pkg::REM_W-1:0] num;

   assign white = ppc_pkg::OPAQUE - alpha;
   assign limit = {alpha, 8'd0};
   assign sum   = 11'(chan[0]) + 11'(chan[1]) + 11'(chan[2])
                + 11'(white) + 11'(white) + 11'(white);

   // rounded dividend c*255 + a/2
   always_comb begin
      for (int k = 0; k < ppc_pkg::CHANNELS; k++) begin
         num[k] = ({8'd0, chan[k]} << 8) - {8'd0, chan[k]} + {9'd0, alpha[7:1]};
      end
   end

   always_comb begin
      stage_in      = '0;
      stage_in.mode = mode;
      case (mode)
         ppc_pkg::MODE_GRAY: begin
            stage_in.gray = (sum > 11'(ppc_pkg::GRAY_MAX)) ? ppc_pkg::GRAY_MAX : sum[9:0];
         end
         ppc_pkg::MODE_COLOUR: begin
            stage_in.alpha = ppc_pkg::OPAQUE;
            for (int k = 0; k < ppc_pkg::CHANNELS; k++) begin
               stage_in.quo[k] = 8'(chan[k] + white);
            end
         end
         ppc_pkg::MODE_UNPREMUL: begin
            stage_in.alpha = alpha;
            for (int k = 0; k < ppc_pkg::CHANNELS; k++) begin
               if (alpha == 8'd0 || alpha == ppc_pkg::OPAQUE) begin
                  stage_in.quo[k] = chan[k];
               end else if (num[k] >= limit) begin
                  stage_in.quo[k] = ppc_pkg::OPAQUE;
               end else begin
                  stage_in.div[k] = 1'b1;
                  stage_in.rem[k] = num[k];
               end
            end
         end
         default: begin
            stage_in = '0;
            stage_in.mode = mode;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

>>> design/ppc_div_cell.sv
`timescale 1ns / 1ps

module ppc_div_cell #(
   parameter int unsigned BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               up_valid,
   input  ppc_pkg::stage_type up_stage,
   output logic               valid_out,
   output ppc_pkg::stage_type stage_out
);

   logic                      valid_ff;
   ppc_pkg::stage_type        stage_ff;
   ppc_pkg::stage_type        stage_in;
   logic [ppc_pkg::REM_W-1:0] shifted;

   assign shifted = {8'd0, up_stage.alpha} << BIT;

   // one quotient bit per channel
   always_comb begin
      stage_in = up_stage;
      for (int k = 0; k < ppc_pkg::CHANNELS; k++) begin
         if (up_stage.div[k] && up_stage.rem[k] >= shifted) begin
            stage_in.rem[k]      = up_stage.rem[k] - shifted;
            stage_in.quo[k][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

>>> design/premultiplied_pixel_converter_top.sv
`timescale 1ns / 1ps

// Premultiplied pixel converter, one ARGB pixel in and one result out per item.
// req: premultiplied red, green, blue and alpha bytes.
// rsp: converted channels, alpha and the 10-bit gray level.
// csr: writes the 2-bit mode (0 gray over white, 1 colour over white,
// 2 un-premultiply); it is always ready and should be written only while
// no item is in flight.
// An accepted item passes through one front cell that forms sums and
// dividends, then a chain of 8 divider cells, each deciding one quotient
// bit for all three channels. The last cell is the output register. The
// chain takes one item per cycle while the receiver does not stall.
// When the receiver stalls the whole chain holds and req.ready drops in the
// same cycle; it stays high while rsp is empty or being taken.
// Reset empties the chain and sets the mode to gray over white.

module premultiplied_pixel_converter_top (
   input  logic      clock,
   input  logic      reset,
   ppc_req_if.sink   req,
   ppc_rsp_if.source rsp,
   ppc_csr_if.sink   csr
);

   localparam int unsigned CELLS = ppc_pkg::CHAN_W;

   logic [1:0]         mode_ff;
   logic               enable;
   logic               valid [0:CELLS];
   ppc_pkg::stage_type stage [0:CELLS];

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ppc_pkg::MODE_GRAY;
      end else if (csr.valid && csr.ready) begin
         mode_ff <= csr.data;
      end
   end

   assign enable    = !valid[CELLS] || rsp.ready;
   assign req.ready = enable;

   ppc_front_cell u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .mode      (mode_ff),
      .up_valid  (req.valid),
      .chan      ({req.in_blue, req.in_green, req.in_red}),
      .alpha     (req.in_alpha),
      .valid_out (valid[0]),
      .stage_out (stage[0])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_div
      ppc_div_cell #(
         .BIT (CELLS - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .up_valid  (valid[i]),
         .up_stage  (stage[i]),
         .valid_out (valid[i+1]),
         .stage_out (stage[i+1])
      );
   end

   assign rsp.valid      = valid[CELLS];
   assign rsp.out_red    = stage[CELLS].quo[0];
   assign rsp.out_green  = stage[CELLS].quo[1];
   assign rsp.out_blue   = stage[CELLS].quo[2];
   assign rsp.out_alpha  = stage[CELLS].alpha;
   assign rsp.gray_level = stage[CELLS].gray;

   a_ready_follows_output : assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("input ready does not follow the output register");

   a_gray_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && stage[CELLS].mode == ppc_pkg::MODE_GRAY) |->
      (rsp.out_red == 8'd0 && rsp.out_green == 8'd0 && rsp.out_blue == 8'd0 &&
       rsp.out_alpha == 8'd0 && rsp.gray_level <= ppc_pkg::GRAY_MAX))
      else $error("gray item carries colour fields or level above range");

   a_colour_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && stage[CELLS].mode == ppc_pkg::MODE_COLOUR) |->
      (rsp.out_alpha == ppc_pkg::OPAQUE && rsp.gray_level == 10'd0))
      else $error("colour item with wrong alpha or nonzero gray level");

   a_stall_holds_chain : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(stage[CELLS])))
      else $error("output moved while the receiver stalled");

endmodule

>>> sim/premultiplied_pixel_converter_top_tb.sv
`timescale 1ns / 1ps

module premultiplied_pixel_converter_top_tb;

   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [9:0] gray;
   } converted_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ppc_req_if req_bus ();
   ppc_rsp_if rsp_bus ();
   ppc_csr_if csr_bus ();

   premultiplied_pixel_converter_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   always #1 clock = ~clock;

   logic [1:0]    model_mode = ppc_pkg::MODE_GRAY;
   converted_type pending_pixels[$];
   int unsigned   fail_count = 0;
   int unsigned   quiet_cycles = 0;
   bit            idle_on = 1'b1;
   bit            hold_request = 1'b0;

   function automatic logic [7:0] unpremultiply(input logic [7:0] c, input logic [7:0] a);
      int unsigned q;
      if (a == 8'd0 || a == ppc_pkg::OPAQUE) begin
         return c;
      end
      q = (int'(c) * 255 + int'(a) / 2) / int'(a);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic converted_type convert_pixel(input logic [1:0] m, input pixel_type p);
      converted_type o;
      logic [7:0]    white;
      logic [11:0]   level;
      o     = '0;
      white = ppc_pkg::OPAQUE - p.alpha;
      case (m)
         ppc_pkg::MODE_GRAY: begin
            level  = 12'(p.red) + 12'(p.green) + 12'(p.blue) + 12'd3 * 12'(white);
            o.gray = (level > 12'(ppc_pkg::GRAY_MAX)) ? ppc_pkg::GRAY_MAX : level[9:0];
         end
         ppc_pkg::MODE_COLOUR: begin
            o.red   = p.red + white;
            o.green = p.green + white;
            o.blue  = p.blue + white;
            o.alpha = ppc_pkg::OPAQUE;
         end
         ppc_pkg::MODE_UNPREMUL: begin
            o.red   = unpremultiply(p.red, p.alpha);
            o.green = unpremultiply(p.green, p.alpha);
            o.blue  = unpremultiply(p.blue, p.alpha);
            o.alpha = p.alpha;
         end
         default: begin
            o = '0;
         end
      endcase
      return o;
   endfunction

   function automatic logic [7:0] pick_extreme();
      logic [7:0] picks [5] = '{8'd0, 8'd1, 8'd2, 8'd254, 8'd255};
      return picks[$urandom_range(4)];
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type   p;
      int unsigned kind;
      kind = $urandom_range(9);
      p    = $urandom;
      if (kind <= 5) begin
         // well-formed premultiplied pixel, channels not above alpha
         p.alpha = 8'($urandom_range(255));
         p.red   = 8'($urandom_range(p.alpha));
         p.green = 8'($urandom_range(p.alpha));
         p.blue  = 8'($urandom_range(p.alpha));
      end else if (kind == 8) begin
         p.alpha = pick_extreme();
      end else if (kind == 9) begin
         p.red   = pick_extreme();
         p.green = pick_extreme();
         p.blue  = pick_extreme();
      end
      return p;
   endfunction

   // mode tracking and expected results
   always @(posedge clock) begin
      if (reset) begin
         model_mode = ppc_pkg::MODE_GRAY;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            model_mode = csr_bus.data;
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_pixels.push_back(convert_pixel(model_mode,
               {req_bus.in_red, req_bus.in_green, req_bus.in_blue, req_bus.in_alpha}));
         end
      end
   end

   // result checking
   always @(posedge clock) begin
      converted_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected item: red %0d green %0d blue %0d alpha %0d gray %0d",
                   rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
                   rsp_bus.out_alpha, rsp_bus.gray_level);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.out_red !== want.red) begin
               $error("out_red expected %0d actual %0d", want.red, rsp_bus.out_red);
               fail_count++;
            end
            if (rsp_bus.out_green !== want.green) begin
               $error("out_green expected %0d actual %0d", want.green, rsp_bus.out_green);
               fail_count++;
            end
            if (rsp_bus.out_blue !== want.blue) begin
               $error("out_blue expected %0d actual %0d", want.blue, rsp_bus.out_blue);
               fail_count++;
            end
            if (rsp_bus.out_alpha !== want.alpha) begin
               $error("out_alpha expected %0d actual %0d", want.alpha, rsp_bus.out_alpha);
               fail_count++;
            end
            if (rsp_bus.gray_level !== want.gray) begin
               $error("gray_level expected %0d actual %0d", want.gray, rsp_bus.gray_level);
               fail_count++;
            end
         end
      end
   end

   // receiver side, with a long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(99) < 26);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_pixel(input pixel_type p);
      while (idle_on && $urandom_range(99) < 26) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.in_red   <= p.red;
      req_bus.in_green <= p.green;
      req_bus.in_blue  <= p.blue;
      req_bus.in_alpha <= p.alpha;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_pixels();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] m);
      drain_pixels();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= m;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_gray_after_reset();
      send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
      send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
      send_pixel('{8'd0, 8'd0, 8'd0, 8'd255});
      // channels above alpha, level saturates
      send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});
      send_pixel('{8'd10, 8'd20, 8'd30, 8'd128});
   endtask

   task automatic test_colour_over_white();
      set_mode(ppc_pkg::MODE_COLOUR);
      send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
      // channel sum wraps to 8 bits
      send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});
      send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
      send_pixel('{8'd100, 8'd50, 8'd0, 8'd200});
   endtask

   task automatic test_unpremultiply();
      set_mode(ppc_pkg::MODE_UNPREMUL);
      // transparent and opaque pass through
      send_pixel('{8'd77, 8'd88, 8'd99, 8'd0});
      send_pixel('{8'd1, 8'd2, 8'd3, 8'd255});
      // quotient above 255 saturates
      send_pixel('{8'd255, 8'd255, 8'd255, 8'd1});
      send_pixel('{8'd127, 8'd64, 8'd255, 8'd254});
      send_pixel('{8'd0, 8'd1, 8'd128, 8'd128});
      send_pixel('{8'd1, 8'd1, 8'd2, 8'd2});
   endtask

   task automatic test_unused_mode();
      set_mode(MODE_UNUSED);
      send_pixel('{8'd255, 8'd255, 8'd255, 8'd128});
      send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
   endtask

   task automatic test_backpressure();
      set_mode(ppc_pkg::MODE_UNPREMUL);
      idle_on      = 1'b0;
      hold_request = 1'b1;
      repeat (40) send_pixel(random_pixel());
      idle_on = 1'b1;
   endtask

   task automatic test_random_stream();
      logic [1:0] m;
      for (int phase = 0; phase < 10; phase++) begin
         m = (phase < 4) ? 2'(phase) : 2'($urandom_range(3));
         set_mode(m);
         // one phase runs without any idling
         idle_on = (phase != 5);
         repeat (190) send_pixel(random_pixel());
      end
      idle_on = 1'b1;
   endtask

   initial begin
      req_bus.valid    <= 1'b0;
      req_bus.in_red   <= '0;
      req_bus.in_green <= '0;
      req_bus.in_blue  <= '0;
      req_bus.in_alpha <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.data     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_gray_after_reset();
      test_colour_over_white();
      test_unpremultiply();
      test_unused_mode();
      test_backpressure();
      test_random_stream();

      drain_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> premultiplied_pixel_converter_top.f
design/ppc_pkg.sv
design/ppc_if.sv
design/ppc_front_cell.sv
design/ppc_div_cell.sv
design/premultiplied_pixel_converter_top.sv
sim/premultiplied_pixel_converter_top_tb.sv
